>>> rtl/cms_pkg.sv
// Shared constants for the multicast switch unit.
`timescale 1ns / 1ps

package cms_pkg;

    localparam int unsigned NUM_INPUTS_DEF    = 4;
    localparam int unsigned NUM_OUTPUTS_DEF   = 4;
    localparam int unsigned PAYLOAD_WIDTH_DEF = 32;

endpackage

>>> rtl/cms_if.sv
// Request and result channel interfaces of the multicast switch unit.
`timescale 1ns / 1ps

interface cms_req_if #(
    parameter int unsigned NUM_INPUTS    = cms_pkg::NUM_INPUTS_DEF,
    parameter int unsigned NUM_OUTPUTS   = cms_pkg::NUM_OUTPUTS_DEF,
    parameter int unsigned PAYLOAD_WIDTH = cms_pkg::PAYLOAD_WIDTH_DEF
) ();
    logic                     valid;
    logic                     ready;
    logic [NUM_INPUTS-1:0]    in_valid;
    logic [NUM_OUTPUTS-1:0]   out_ready;
    logic [PAYLOAD_WIDTH-1:0] in_payload [NUM_INPUTS];

    modport source (output valid, output in_valid, output out_ready, output in_payload,
                    input ready);
    modport sink   (input valid, input in_valid, input out_ready, input in_payload,
                    output ready);
endinterface

interface cms_res_if #(
    parameter int unsigned NUM_INPUTS    = cms_pkg::NUM_INPUTS_DEF,
    parameter int unsigned NUM_OUTPUTS   = cms_pkg::NUM_OUTPUTS_DEF,
    parameter int unsigned PAYLOAD_WIDTH = cms_pkg::PAYLOAD_WIDTH_DEF
) ();
    logic                     valid;
    logic                     ready;
    logic [NUM_INPUTS-1:0]    in_ready;
    logic [NUM_OUTPUTS-1:0]   out_valid;
    logic [PAYLOAD_WIDTH-1:0] out_payload [NUM_OUTPUTS];

    modport source (output valid, output in_ready, output out_valid, output out_payload,
                    input ready);
    modport sink   (input valid, input in_ready, input out_valid, input out_payload,
                    output ready);
endinterface

>>> rtl/cms_xbar.sv
// Crossbar evaluation: fork readiness, output valids and payload selection.
`timescale 1ns / 1ps

module cms_xbar #(
    parameter int unsigned NUM_INPUTS    = cms_pkg::NUM_INPUTS_DEF,
    parameter int unsigned NUM_OUTPUTS   = cms_pkg::NUM_OUTPUTS_DEF,
    parameter int unsigned PAYLOAD_WIDTH = cms_pkg::PAYLOAD_WIDTH_DEF
) (
    input  logic [NUM_INPUTS*NUM_OUTPUTS-1:0] route,
    input  logic [NUM_INPUTS-1:0]             in_valid,
    input  logic [NUM_OUTPUTS-1:0]            out_ready,
    input  logic [PAYLOAD_WIDTH-1:0]          in_payload  [NUM_INPUTS],
    output logic [NUM_INPUTS-1:0]             in_ready,
    output logic [NUM_OUTPUTS-1:0]            out_valid,
    output logic [PAYLOAD_WIDTH-1:0]          out_payload [NUM_OUTPUTS]
);

    logic [NUM_OUTPUTS-1:0] row [NUM_INPUTS];

    always_comb
    begin
        for (int i = 0; i < NUM_INPUTS; i++)
        begin
            row[i] = route[i*NUM_OUTPUTS +: NUM_OUTPUTS];
        end
    end

    // an input moves only when every branch of its fork can take it
    always_comb
    begin
        for (int i = 0; i < NUM_INPUTS; i++)
        begin
            in_ready[i] = (|row[i]) && (&(~row[i] | out_ready));
        end
    end

    always_comb
    begin
        logic [NUM_OUTPUTS-1:0] self_bit;
        for (int o = 0; o < NUM_OUTPUTS; o++)
        begin
            self_bit       = '0;
            self_bit[o]    = 1'b1;
            out_valid[o]   = 1'b0;
            out_payload[o] = '0;
            // ascending scan: highest routed input wins the payload
            for (int i = 0; i < NUM_INPUTS; i++)
            begin
                if (row[i][o])
                begin
                    if (in_valid[i] && (&(~row[i] | out_ready | self_bit)))
                    begin
                        out_valid[o] = 1'b1;
                    end
                    out_payload[o] = in_payload[i];
                end
            end
        end
    end

endmodule

>>> rtl/configurable_multicast_switch_unit.sv
// Top level of the configurable multicast switch unit.
`timescale 1ns / 1ps

// Each request carries one cycle's snapshot of the switch ports (input valids,
// output readies, input payloads); each result gives the matching input readies,
// output valids and output payloads under the route matrix in cfg_data
// (bit input*NUM_OUTPUTS+output). A request is registered, passed through the
// crossbar logic and registered again, and one request is taken every cycle while
// results are drained.
// Write the route matrix with cfg_we only while no request is in flight.
module configurable_multicast_switch_unit #(
    parameter int unsigned NUM_INPUTS    = cms_pkg::NUM_INPUTS_DEF,
    parameter int unsigned NUM_OUTPUTS   = cms_pkg::NUM_OUTPUTS_DEF,
    parameter int unsigned PAYLOAD_WIDTH = cms_pkg::PAYLOAD_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [NUM_INPUTS*NUM_OUTPUTS-1:0] cfg_data,
    cms_req_if.sink                           req,
    cms_res_if.source                         res
);

    localparam int unsigned ROUTE_WIDTH = NUM_INPUTS * NUM_OUTPUTS;

    logic [ROUTE_WIDTH-1:0]   route_reg;

    logic                     s1_valid_reg;
    logic [NUM_INPUTS-1:0]    s1_in_valid_reg;
    logic [NUM_OUTPUTS-1:0]   s1_out_ready_reg;
    logic [PAYLOAD_WIDTH-1:0] s1_payload_reg [NUM_INPUTS];

    logic                     s2_valid_reg;
    logic [NUM_INPUTS-1:0]    s2_in_ready_reg;
    logic [NUM_OUTPUTS-1:0]   s2_out_valid_reg;
    logic [PAYLOAD_WIDTH-1:0] s2_payload_reg [NUM_OUTPUTS];

    logic [NUM_INPUTS-1:0]    in_ready_next;
    logic [NUM_OUTPUTS-1:0]   out_valid_next;
    logic [PAYLOAD_WIDTH-1:0] payload_next [NUM_OUTPUTS];

    logic s1_load;
    logic s2_load;
    logic s2_free;

    assign s2_free   = !s2_valid_reg || res.ready;
    assign s2_load   = s1_valid_reg && s2_free;
    assign req.ready = !s1_valid_reg || s2_free;
    assign s1_load   = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            route_reg <= '0;
        end
        else if (cfg_we)
        begin
            route_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_in_valid_reg  <= req.in_valid;
            s1_out_ready_reg <= req.out_ready;
            s1_payload_reg   <= req.in_payload;
        end
        if (s2_load)
        begin
            s2_in_ready_reg  <= in_ready_next;
            s2_out_valid_reg <= out_valid_next;
            s2_payload_reg   <= payload_next;
        end
    end

    cms_xbar #(
        .NUM_INPUTS    (NUM_INPUTS),
        .NUM_OUTPUTS   (NUM_OUTPUTS),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_xbar (
        .route       (route_reg),
        .in_valid    (s1_in_valid_reg),
        .out_ready   (s1_out_ready_reg),
        .in_payload  (s1_payload_reg),
        .in_ready    (in_ready_next),
        .out_valid   (out_valid_next),
        .out_payload (payload_next)
    );

    assign res.valid       = s2_valid_reg;
    assign res.in_ready    = s2_in_ready_reg;
    assign res.out_valid   = s2_out_valid_reg;
    assign res.out_payload = s2_payload_reg;

endmodule

>>> tb/tb.sv
// Self-checking testbench for the configurable multicast switch unit.
`timescale 1ns / 1ps

module tb;

    localparam int unsigned NI      = cms_pkg::NUM_INPUTS_DEF;
    localparam int unsigned NO      = cms_pkg::NUM_OUTPUTS_DEF;
    localparam int unsigned PW      = cms_pkg::PAYLOAD_WIDTH_DEF;
    localparam int unsigned ROUTE_W = NI * NO;

    localparam logic [ROUTE_W-1:0] NO_ROUTES       = 16'h0000;
    localparam logic [ROUTE_W-1:0] ALL_ROUTES      = 16'hFFFF;
    localparam logic [ROUTE_W-1:0] STRAIGHT_ROUTES = 16'h8421;

    localparam int unsigned MAX_IDLE      = 13;
    localparam int unsigned PHASES        = 8;
    localparam int unsigned PHASE_ITEMS   = 94;
    localparam int unsigned CYCLE_LIMIT   = 200000;

    typedef struct packed {
        logic [NI-1:0]         in_valid;
        logic [NO-1:0]         out_ready;
        logic [NI-1:0][PW-1:0] payload;
    } switch_req_t;

    typedef struct packed {
        logic [NI-1:0]         in_ready;
        logic [NO-1:0]         out_valid;
        logic [NO-1:0][PW-1:0] payload;
    } switch_res_t;

    typedef struct {
        logic [ROUTE_W-1:0] routes;
        switch_req_t        stim;
        bit                 known;
        switch_res_t        want;
    } vector_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [ROUTE_W-1:0] cfg_data;

    cms_req_if req_ch ();
    cms_res_if res_ch ();

    configurable_multicast_switch_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .req      (req_ch),
        .res      (res_ch)
    );

    // predictor's copy of the route matrix
    logic [ROUTE_W-1:0] route_copy;

    switch_res_t awaiting_accept [$];
    switch_res_t results_due     [$];
    vector_t     vectors         [$];

    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned route_writes;
    int unsigned random_sent;
    int unsigned cycle_count;
    bit          calm;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic switch_res_t crossbar_outcome(input logic [ROUTE_W-1:0] routes,
                                                     input switch_req_t r);
        switch_res_t   outcome;
        logic [NO-1:0] fan;
        logic [NO-1:0] self_bit;
        outcome = '0;
        for (int i = 0; i < NI; i++)
        begin
            fan = routes[i*NO +: NO];
            outcome.in_ready[i] = (fan != '0) && ((fan & ~r.out_ready) == '0);
        end
        for (int o = 0; o < NO; o++)
        begin
            self_bit = '0;
            self_bit[o] = 1'b1;
            for (int i = 0; i < NI; i++)
            begin
                fan = routes[i*NO +: NO];
                if (fan[o])
                begin
                    // fork peers other than this output must all be ready
                    if (r.in_valid[i] && ((fan & ~r.out_ready & ~self_bit) == '0))
                        outcome.out_valid[o] = 1'b1;
                    // highest routed input wins, valid or not
                    outcome.payload[o] = r.payload[i];
                end
            end
        end
        return outcome;
    endfunction

    function automatic void add_row(input logic [ROUTE_W-1:0] routes,
                                    input logic [NI-1:0] valid, input logic [NO-1:0] ready,
                                    input logic [NI*PW-1:0] pay, input bit known,
                                    input logic [NI-1:0] want_ir, input logic [NO-1:0] want_ov,
                                    input logic [NO*PW-1:0] want_pay);
        vector_t v;
        v.routes          = routes;
        v.stim.in_valid   = valid;
        v.stim.out_ready  = ready;
        v.stim.payload    = pay;
        v.known           = known;
        v.want.in_ready   = want_ir;
        v.want.out_valid  = want_ov;
        v.want.payload    = want_pay;
        vectors = {vectors, v};
    endfunction

    task automatic settle(input int unsigned tail);
        req_ch.valid <= 1'b0;
        while (awaiting_accept.size() != 0 || results_due.size() != 0)
            @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    task automatic write_routes(input logic [ROUTE_W-1:0] value);
        settle(4);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we     <= 1'b0;
        route_copy = value;
        route_writes++;
    endtask

    task automatic send_request(input switch_req_t r, input switch_res_t want);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        awaiting_accept = {awaiting_accept, want};
        req_ch.valid     <= 1'b1;
        req_ch.in_valid  <= r.in_valid;
        req_ch.out_ready <= r.out_ready;
        for (int i = 0; i < NI; i++)
            req_ch.in_payload[i] <= r.payload[i];
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // result checker and request acceptance tracking, one process
    always @(posedge clk)
    begin
        switch_res_t exp_res;
        switch_res_t taken;
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                results_seen++;
                if (results_due.size() == 0)
                begin
                    $error("unexpected result: in_ready %h out_valid %h",
                           res_ch.in_ready, res_ch.out_valid);
                    mismatches++;
                end
                else
                begin
                    exp_res = results_due.pop_front();
                    if (res_ch.in_ready !== exp_res.in_ready)
                    begin
                        $error("in_ready: expected %h, got %h",
                               exp_res.in_ready, res_ch.in_ready);
                        mismatches++;
                    end
                    if (res_ch.out_valid !== exp_res.out_valid)
                    begin
                        $error("out_valid: expected %h, got %h",
                               exp_res.out_valid, res_ch.out_valid);
                        mismatches++;
                    end
                    for (int o = 0; o < NO; o++)
                        if (res_ch.out_payload[o] !== exp_res.payload[o])
                        begin
                            $error("out_payload_%0d: expected %h, got %h",
                                   o, exp_res.payload[o], res_ch.out_payload[o]);
                            mismatches++;
                        end
                end
            end
            if (req_ch.valid && req_ch.ready && awaiting_accept.size() != 0)
            begin
                taken = awaiting_accept.pop_front();
                results_due = {results_due, taken};
            end
        end
    end

    // result side back-pressure
    initial
    begin
        int unsigned stall;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall != 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_ch.valid);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        switch_req_t        stim;
        switch_res_t        want;
        logic [ROUTE_W-1:0] routes;

        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_data            <= '0;
        req_ch.valid        <= 1'b0;
        req_ch.in_valid     <= '0;
        req_ch.out_ready    <= '0;
        for (int i = 0; i < NI; i++)
            req_ch.in_payload[i] <= '0;
        route_copy   = NO_ROUTES;
        mismatches   = 0;
        results_seen = 0;
        route_writes = 0;
        random_sent  = 0;
        calm         = 1'b0;

        // reset matrix: nothing routed, everything zero
        add_row(NO_ROUTES, 4'hF, 4'hF, {32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0},
                1, 4'h0, 4'h0, '0);
        add_row(NO_ROUTES, 4'h0, 4'h0, '0, 1, 4'h0, 4'h0, '0);
        // full mesh: every output shows input three
        add_row(ALL_ROUTES, 4'hF, 4'hF, {32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0},
                1, 4'hF, 4'hF, {4{32'hFFFF_FFFF}});
        add_row(ALL_ROUTES, 4'hF, 4'hE, {32'h0, 32'h1234_5678, 32'hFFFF_FFFF, 32'h8000_0001},
                1, 4'h0, 4'h1, '0);
        // payload passes even with no valid
        add_row(ALL_ROUTES, 4'h0, 4'hF, {32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0},
                1, 4'hF, 4'h0, {4{32'hFFFF_FFFF}});
        add_row(ALL_ROUTES, 4'h0, 4'h0, {32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF}, 0, '0, '0, '0);
        // straight through
        add_row(STRAIGHT_ROUTES, 4'hF, 4'hF,
                {32'h0, 32'h1234_5678, 32'hFFFF_FFFF, 32'h8000_0001},
                1, 4'hF, 4'hF, {32'h0, 32'h1234_5678, 32'hFFFF_FFFF, 32'h8000_0001});
        add_row(STRAIGHT_ROUTES, 4'h5, 4'h3,
                {32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0},
                1, 4'h3, 4'h5, {32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0});
        // input zero broadcast
        add_row(16'h000F, 4'h1, 4'hF, {32'h0, 32'h0, 32'h0, 32'hDEAD_BEEF}, 0, '0, '0, '0);
        add_row(16'h000F, 4'h1, 4'h7, {32'h1, 32'h2, 32'h3, 32'hFFFF_FFFF}, 0, '0, '0, '0);
        add_row(16'h000F, 4'hE, 4'hF, {32'hFFFF_FFFF, 32'h0, 32'h0, 32'h5A5A_5A5A},
                0, '0, '0, '0);
        // fan-in: all inputs onto output zero
        add_row(16'h1111, 4'h1, 4'h1, {32'hCAFE_0003, 32'h2, 32'h1, 32'h0}, 0, '0, '0, '0);
        add_row(16'h1111, 4'h0, 4'h0, {32'hFFFF_FFFF, 32'h2, 32'h1, 32'h0}, 0, '0, '0, '0);
        add_row(16'h1111, 4'h8, 4'hE, {32'h0, 32'hFFFF_FFFF, 32'h1, 32'h0}, 0, '0, '0, '0);
        // single corner routes
        add_row(16'h8000, 4'h8, 4'h8, {32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0}, 0, '0, '0, '0);
        add_row(16'h8000, 4'h7, 4'h7, {32'h8000_0000, 32'h0, 32'h0, 32'h0}, 0, '0, '0, '0);
        add_row(16'h0001, 4'h1, 4'h1, {32'h0, 32'h0, 32'h0, 32'h0000_0001}, 0, '0, '0, '0);
        // two-way fork from input one, readiness split
        add_row(16'h0030, 4'h2, 4'h1, {32'h0, 32'h0, 32'h7777_7777, 32'h0}, 0, '0, '0, '0);
        add_row(16'h0030, 4'h2, 4'h2, {32'h0, 32'h0, 32'h8888_8888, 32'h0}, 0, '0, '0, '0);
        add_row(16'h0030, 4'h2, 4'h3, {32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0}, 0, '0, '0, '0);
        add_row(16'hA5C3, 4'h9, 4'h6, {32'h1357_9BDF, 32'h2468_ACE0, 32'hF0F0_F0F0, 32'h0F0F_0F0F},
                0, '0, '0, '0);
        add_row(16'hA5C3, 4'hF, 4'hF, {32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0},
                0, '0, '0, '0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (vectors[k])
        begin
            if (vectors[k].routes != route_copy)
                write_routes(vectors[k].routes);
            want = vectors[k].known ? vectors[k].want
                                    : crossbar_outcome(route_copy, vectors[k].stim);
            send_request(vectors[k].stim, want);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            unique case (ph)
                0:       routes = ALL_ROUTES;
                1:       routes = NO_ROUTES;
                2:       routes = STRAIGHT_ROUTES;
                3:       routes = ROUTE_W'($urandom & $urandom);
                default: routes = ROUTE_W'($urandom_range(0, 65535));
            endcase
            write_routes(routes);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 32 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                // hold off until the pipe is empty, mid-phase
                if (ph == 4 && n == PHASE_ITEMS / 2)
                    settle(0);
                stim.in_valid  = NI'($urandom);
                stim.out_ready = NO'($urandom);
                for (int i = 0; i < NI; i++)
                    stim.payload[i] = PW'($urandom);
                send_request(stim, crossbar_outcome(route_copy, stim));
                random_sent++;
            end
        end

        calm = 1'b0;
        settle(8);

        $display("Covered %0d table requests and %0d random requests over %0d route writes;",
                 vectors.size(), random_sent, route_writes);
        $display("%0d results compared, with forks, fan-in, unrouted ports and stalls.",
                 results_seen);
        if (mismatches == 0 && results_due.size() == 0 && awaiting_accept.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
